// ----- hdl/sfms_pkg.sv -----
// sfms_pkg: shared types and constants for the first-match substring search
// depends on nothing; imported by every module of the block
`default_nettype none

package sfms_pkg;

  // fixed field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned START_W = 17;
  localparam int unsigned POS_W   = 17;

  // request type codes
  localparam logic REQ_PATTERN = 1'b0;
  localparam logic REQ_TEXT    = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_FOUND       = 2'd0,
    ST_NOT_FOUND   = 2'd1,
    ST_START_RANGE = 2'd2,
    ST_OVER_CAP    = 2'd3
  } status_t;

endpackage

`default_nettype wire

// ----- hdl/sfms_match.sv -----
// sfms_match: parallel compare of the text window against the right-aligned pattern
// depends on sfms_pkg
`default_nettype none

module sfms_match #(
  parameter int unsigned MAX_PATTERN = 64,
  parameter int unsigned LW          = 7
) (
  input  wire logic [sfms_pkg::BYTE_W-1:0] win [MAX_PATTERN],
  input  wire logic [sfms_pkg::BYTE_W-1:0] pat [MAX_PATTERN],
  input  wire logic [LW-1:0]               len,
  output logic                             hit
);
  import sfms_pkg::*;

  logic [MAX_PATTERN-1:0] ok;

  // entry i takes part when it lies in the last len slots
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cmp
    localparam logic [LW-1:0] DIST = LW'(MAX_PATTERN - i);
    assign ok[i] = (DIST > len) || (win[i] == pat[i]);
  end

  assign hit = &ok;

endmodule

`default_nettype wire

// ----- hdl/substring_first_match_search.sv -----
// substring_first_match_search: throughput one byte per cycle, but a final text byte
// waits while an untaken result is held; a byte sits in an input register, then job
// state and the window compare update in one pass; the result of the last text byte
// waits in an output register while new bytes still enter
// rst is synchronous, active high: clears job state and sets start_position to 1
// depends on sfms_pkg and sfms_match
`default_nettype none

module substring_first_match_search #(
  parameter int unsigned MAX_PATTERN = 64,
  parameter int unsigned MAX_TEXT    = 65536
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration write
  input  wire logic                          cfg_wr_en,
  input  wire logic [sfms_pkg::START_W-1:0]  cfg_wr_data,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          req_type,
  input  wire logic [sfms_pkg::BYTE_W-1:0]   data_byte,
  input  wire logic                          last,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output sfms_pkg::status_t                  status,
  output logic [sfms_pkg::POS_W-1:0]         position
);
  import sfms_pkg::*;

  localparam int unsigned LW   = $clog2(MAX_PATTERN + 1);
  localparam int unsigned CW   = $clog2(MAX_TEXT + 1);
  localparam int unsigned CMPW = ((CW > START_W) ? CW : START_W) + 2;

  // configuration register
  logic [START_W-1:0] start_position;

  // input register
  logic              in_q_valid;
  logic              in_q_req;
  logic [BYTE_W-1:0] in_q_byte;
  logic              in_q_last;

  // job state
  logic [BYTE_W-1:0] pattern_store [MAX_PATTERN];
  logic [BYTE_W-1:0] text_window   [MAX_PATTERN];
  logic [BYTE_W-1:0] window_next   [MAX_PATTERN];
  logic [LW-1:0]     pattern_length, pattern_length_next;
  logic [CW-1:0]     text_count, text_count_next;
  logic              match_found, match_found_next;
  logic [CW-1:0]     match_position, match_position_next;
  logic              capacity_exceeded, capacity_exceeded_next;
  logic              pattern_complete, pattern_complete_next;

  logic              pat_shift;
  logic              win_shift;
  logic              hit;
  logic              consume;
  logic              gives_result;
  logic [CW-1:0]     cand;
  logic              cand_ok;
  status_t           status_next;
  logic [CW-1:0]     pos_next;

  // a byte leaves the input register unless it would produce a result
  // while the output register still holds one that is not taken
  assign gives_result = (in_q_req == REQ_TEXT) && in_q_last;
  assign consume      = in_q_valid && (!gives_result || !out_valid || out_ready);
  assign in_ready     = !in_q_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_position <= START_W'(1);
    end else if (cfg_wr_en) begin
      start_position <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q_req  <= req_type;
      in_q_byte <= data_byte;
      in_q_last <= last;
    end
  end

  // window after shifting in the current byte, newest at the top slot
  always_comb begin
    for (int i = 0; i < MAX_PATTERN - 1; i++) begin
      window_next[i] = text_window[i+1];
    end
    window_next[MAX_PATTERN-1] = in_q_byte;
  end

  sfms_match #(
    .MAX_PATTERN (MAX_PATTERN),
    .LW          (LW)
  ) u_match (
    .win (window_next),
    .pat (pattern_store),
    .len (pattern_length),
    .hit (hit)
  );

  // candidate start of a match ending at this byte, and whether it is
  // at or after the start position: count + 2 >= start + len
  assign cand    = CW'(text_count + CW'(1) - CW'(pattern_length) + CW'(1));
  assign cand_ok = (start_position != '0)
                && (pattern_length != '0)
                && (CMPW'(text_count) + CMPW'(1) >= CMPW'(pattern_length))
                && (CMPW'(text_count) + CMPW'(2)
                    >= CMPW'(start_position) + CMPW'(pattern_length));

  always_comb begin
    pattern_length_next    = pattern_length;
    text_count_next        = text_count;
    match_found_next       = match_found;
    match_position_next    = match_position;
    capacity_exceeded_next = capacity_exceeded;
    pattern_complete_next  = pattern_complete;
    pat_shift              = 1'b0;
    win_shift              = 1'b0;
    status_next            = ST_NOT_FOUND;
    pos_next               = '0;

    if (in_q_req == REQ_PATTERN) begin
      // a pattern byte after a finished pattern opens a new job
      if (pattern_complete) begin
        pattern_length_next    = '0;
        text_count_next        = '0;
        match_found_next       = 1'b0;
        match_position_next    = '0;
        capacity_exceeded_next = 1'b0;
        pattern_complete_next  = 1'b0;
      end
      if (pattern_length_next < LW'(MAX_PATTERN)) begin
        pat_shift           = 1'b1;
        pattern_length_next = pattern_length_next + LW'(1);
      end else begin
        capacity_exceeded_next = 1'b1;
      end
      if (in_q_last) begin
        pattern_complete_next = 1'b1;
      end
    end else begin
      pattern_complete_next = 1'b1;
      if (text_count < CW'(MAX_TEXT)) begin
        text_count_next = text_count + CW'(1);
        win_shift       = 1'b1;
        if (!match_found && cand_ok && hit) begin
          match_found_next    = 1'b1;
          match_position_next = cand;
        end
      end else begin
        capacity_exceeded_next = 1'b1;
      end

      // final text byte: status by priority, then the job is cleared
      if (capacity_exceeded_next) begin
        status_next = ST_OVER_CAP;
      end else if ((start_position == '0)
                || (CMPW'(start_position) > CMPW'(text_count_next))) begin
        status_next = ST_START_RANGE;
      end else if (match_found_next) begin
        status_next = ST_FOUND;
        pos_next    = match_position_next;
      end else begin
        status_next = ST_NOT_FOUND;
      end
      if (in_q_last) begin
        pattern_length_next    = '0;
        text_count_next        = '0;
        match_found_next       = 1'b0;
        match_position_next    = '0;
        capacity_exceeded_next = 1'b0;
        pattern_complete_next  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length    <= '0;
      text_count        <= '0;
      match_found       <= 1'b0;
      match_position    <= '0;
      capacity_exceeded <= 1'b0;
      pattern_complete  <= 1'b0;
    end else if (consume) begin
      pattern_length    <= pattern_length_next;
      text_count        <= text_count_next;
      match_found       <= match_found_next;
      match_position    <= match_position_next;
      capacity_exceeded <= capacity_exceeded_next;
      pattern_complete  <= pattern_complete_next;
    end
  end

  // pattern and window are shift lines; only slots filled in this job are compared
  always_ff @(posedge clk) begin
    if (consume && pat_shift) begin
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
        pattern_store[i] <= pattern_store[i+1];
      end
      pattern_store[MAX_PATTERN-1] <= in_q_byte;
    end
    if (consume && win_shift) begin
      text_window <= window_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (consume && gives_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && gives_result) begin
      status   <= status_next;
      position <= POS_W'(pos_next);
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sfms_checker.sv -----
// sfms_checker: port-level assertions for substring_first_match_search
// depends on sfms_pkg; bound to the top level below
`default_nettype none

module sfms_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire sfms_pkg::status_t            status,
  input wire logic [sfms_pkg::POS_W-1:0]   position
);
  import sfms_pkg::*;

  // a found result always carries a 1-based position
  a_found_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FOUND) |-> (position != '0))
    else $error("found result with position zero");

  // every other status carries position zero
  a_other_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_FOUND) |-> (position == '0))
    else $error("nonzero position without a match");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(position)))
    else $error("result changed while stalled");

  // reset empties the output register
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind substring_first_match_search sfms_checker u_sfms_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status),
  .position  (position)
);

`default_nettype wire
